// ===== design/pmvct_pkg.sv =====
// ----------------------------------------------------------------------------
// pmvct_pkg
// shared types and constants for the page map / valid count table
// ----------------------------------------------------------------------------
package pmvct_pkg;

  localparam int LOGICAL_PAGES_DEF = 4096;
  localparam int USER_BLOCKS_DEF   = 64;

  localparam logic [2:0] KIND_UPDATE      = 3'd0;
  localparam logic [2:0] KIND_LOOKUP      = 3'd1;
  localparam logic [2:0] KIND_SET_OPEN    = 3'd2;
  localparam logic [2:0] KIND_SET_STATE   = 3'd3;
  localparam logic [2:0] KIND_FIND_FREE   = 3'd4;
  localparam logic [2:0] KIND_FIND_VICTIM = 3'd5;

  localparam logic [1:0]  MODE_CLOSED = 2'd0;
  localparam logic [1:0]  MODE_OPEN   = 2'd1;
  localparam logic [12:0] COUNT_MAX   = 13'h1fff;
  localparam logic [15:0] ERASE_MAX   = 16'hffff;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] lpn;
    logic [5:0]  block;
    logic [7:0]  wordline;
    logic        unmap;
    logic        on_open;
    logic        journal_busy;
    logic [1:0]  block_state;
    logic        skip_first;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        map_valid;
    logic [5:0]  map_block;
    logic [7:0]  map_wordline;
    logic        found;
    logic [5:0]  found_block;
    logic [12:0] found_count;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] blk;
    logic [7:0] wl;
  } map_entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] count;
    logic [15:0] erase;
  } blk_entry_t;

endpackage

// ===== design/pmvct_ram.sv =====
// ----------------------------------------------------------------------------
// pmvct_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module pmvct_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/page_map_valid_count_table.sv =====
// ----------------------------------------------------------------------------
// page_map_valid_count_table
// flash translation table: page map plus per-block state and counters
// ----------------------------------------------------------------------------
// in channel (in_valid/in_ready/in_data) takes one command item, out channel
// (out_valid/out_ready/out_data) returns exactly one result item for it.
// one item is worked at a time; in_ready is high only when the engine is idle.
// lookup reads the map entry; set open and set state rewrite the block entry.
// an update dropped as busy goes straight to the result; otherwise a map
// read-modify-write, then the old block count and the new block count, each
// a read-modify-write on the block memory; unknown kinds go straight to the
// result. find free / find victim scan every block, one block memory read
// per cycle. in_ready returns in the cycle after the result is loaded.
// after reset a clearing pass writes both memories to zero (unmapped,
// closed, zero counts); in_ready stays low during it.
// the result sits in an output register; if the receiver stalls, the next
// item may be accepted and worked but its result waits until the register
// is free.
// ----------------------------------------------------------------------------
module page_map_valid_count_table #(
  parameter int LOGICAL_PAGES = pmvct_pkg::LOGICAL_PAGES_DEF,
  parameter int USER_BLOCKS   = pmvct_pkg::USER_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pmvct_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pmvct_pkg::out_item_t out_data
);

  localparam int MAW   = (LOGICAL_PAGES > 1) ? $clog2(LOGICAL_PAGES) : 1;
  localparam int BAW   = (USER_BLOCKS > 1) ? $clog2(USER_BLOCKS) : 1;
  localparam int BCW   = $clog2(USER_BLOCKS + 1);
  localparam int CLR_N = (LOGICAL_PAGES > USER_BLOCKS) ? LOGICAL_PAGES : USER_BLOCKS;
  localparam int CAW   = $clog2(CLR_N);
  localparam int MW    = $bits(pmvct_pkg::map_entry_t);
  localparam int BW    = $bits(pmvct_pkg::blk_entry_t);
  localparam int OW    = $bits(pmvct_pkg::out_item_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_UMAP, S_DEC, S_RINC, S_INC, S_LOOK, S_BWR, S_SCAN, S_FIN
  } state_t;

  state_t               state;
  logic [CAW-1:0]       clr_idx;
  pmvct_pkg::in_item_t  req;
  pmvct_pkg::out_item_t res;
  logic [BAW-1:0]       dec_addr;
  logic [BCW-1:0]       issue_idx;
  logic                 ev;
  logic [BAW-1:0]       ev_idx;
  logic                 skip;

  logic                    accept;
  logic                    busy_in;
  logic                    map_we;
  logic [MAW-1:0]          map_waddr;
  logic [MAW-1:0]          map_raddr;
  pmvct_pkg::map_entry_t   map_wdata;
  logic [MW-1:0]           map_rbits;
  pmvct_pkg::map_entry_t   map_rd;
  logic                    blk_we;
  logic [BAW-1:0]          blk_waddr;
  logic [BAW-1:0]          blk_raddr;
  pmvct_pkg::blk_entry_t   blk_wdata;
  logic [BW-1:0]           blk_rbits;
  pmvct_pkg::blk_entry_t   blk_rd;
  logic                    old_in_range;
  logic                    qual;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign busy_in  = (in_data.kind == pmvct_pkg::KIND_UPDATE) && !in_data.on_open &&
                    in_data.journal_busy;
  assign map_rd   = pmvct_pkg::map_entry_t'(map_rbits);
  assign blk_rd   = pmvct_pkg::blk_entry_t'(blk_rbits);
  assign map_raddr = MAW'(in_data.lpn);
  assign old_in_range = map_rd.valid && (32'(map_rd.blk) < USER_BLOCKS);

  pmvct_ram #(.WIDTH(MW), .DEPTH(LOGICAL_PAGES), .AW(MAW)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rbits)
  );

  pmvct_ram #(.WIDTH(BW), .DEPTH(USER_BLOCKS), .AW(BAW)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rbits)
  );

  always_comb begin
    map_we    = 1'b0;
    map_waddr = MAW'(req.lpn);
    map_wdata = '0;
    blk_we    = 1'b0;
    blk_waddr = BAW'(req.block);
    blk_wdata = blk_rd;
    blk_raddr = BAW'(req.block);
    case (state)
      S_CLEAR: begin
        map_we    = (32'(clr_idx) < LOGICAL_PAGES);
        map_waddr = MAW'(clr_idx);
        blk_we    = (32'(clr_idx) < USER_BLOCKS);
        blk_waddr = BAW'(clr_idx);
        blk_wdata = '0;
      end
      S_IDLE: begin
        blk_raddr = BAW'(in_data.block);
      end
      S_UMAP: begin
        map_we = 1'b1;
        if (!req.unmap) begin
          map_wdata = {1'b1, req.block, req.wordline};
        end
        if (old_in_range) begin
          blk_raddr = BAW'(map_rd.blk);
        end
      end
      S_DEC: begin
        blk_we    = 1'b1;
        blk_waddr = dec_addr;
        if (blk_rd.count != '0) begin
          blk_wdata.count = blk_rd.count - 13'd1;
        end
      end
      S_INC: begin
        blk_we = 1'b1;
        if (blk_rd.count != pmvct_pkg::COUNT_MAX) begin
          blk_wdata.count = blk_rd.count + 13'd1;
        end
      end
      S_BWR: begin
        blk_we = 1'b1;
        if (req.kind == pmvct_pkg::KIND_SET_OPEN) begin
          blk_wdata.mode = pmvct_pkg::MODE_OPEN;
          if (req.wordline == '0 && blk_rd.erase != pmvct_pkg::ERASE_MAX) begin
            blk_wdata.erase = blk_rd.erase + 16'd1;
          end
        end else begin
          blk_wdata.mode = req.block_state;
        end
      end
      S_SCAN: begin
        blk_raddr = BAW'(issue_idx);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (req.kind == pmvct_pkg::KIND_FIND_FREE) begin
      qual = (blk_rd.mode == pmvct_pkg::MODE_CLOSED) && (blk_rd.count == '0);
    end else begin
      qual = (blk_rd.mode == pmvct_pkg::MODE_CLOSED) && (blk_rd.count != '0) &&
             (!res.found || blk_rd.count < res.found_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      ev        <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CAW'(1);
          if (clr_idx == CAW'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req <= in_data;
            res <= pmvct_pkg::out_item_t'({busy_in, (OW - 1)'(0)});
            case (in_data.kind)
              pmvct_pkg::KIND_UPDATE: begin
                if (!busy_in && (32'(in_data.lpn) < LOGICAL_PAGES) &&
                    (in_data.unmap || 32'(in_data.block) < USER_BLOCKS)) begin
                  state <= S_UMAP;
                end else begin
                  state <= S_FIN;
                end
              end
              pmvct_pkg::KIND_LOOKUP: begin
                if (32'(in_data.lpn) < LOGICAL_PAGES) begin
                  state <= S_LOOK;
                end else begin
                  state <= S_FIN;
                end
              end
              pmvct_pkg::KIND_SET_OPEN, pmvct_pkg::KIND_SET_STATE: begin
                if (32'(in_data.block) < USER_BLOCKS) begin
                  state <= S_BWR;
                end else begin
                  state <= S_FIN;
                end
              end
              pmvct_pkg::KIND_FIND_FREE, pmvct_pkg::KIND_FIND_VICTIM: begin
                issue_idx <= '0;
                ev        <= 1'b0;
                skip      <= in_data.skip_first;
                state     <= S_SCAN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_UMAP: begin
          if (old_in_range) begin
            dec_addr <= BAW'(map_rd.blk);
            state    <= S_DEC;
          end else if (!req.unmap) begin
            state <= S_INC;
          end else begin
            state <= S_FIN;
          end
        end
        S_DEC: begin
          state <= req.unmap ? S_FIN : S_RINC;
        end
        S_RINC: begin
          state <= S_INC;
        end
        S_INC, S_BWR: begin
          state <= S_FIN;
        end
        S_LOOK: begin
          res.map_valid <= map_rd.valid;
          if (map_rd.valid) begin
            res.map_block    <= map_rd.blk;
            res.map_wordline <= map_rd.wl;
          end
          state <= S_FIN;
        end
        S_SCAN: begin
          if (32'(issue_idx) < USER_BLOCKS) begin
            issue_idx <= issue_idx + BCW'(1);
            ev        <= 1'b1;
            ev_idx    <= BAW'(issue_idx);
          end else begin
            ev <= 1'b0;
          end
          if (ev) begin
            if (qual) begin
              if (req.kind == pmvct_pkg::KIND_FIND_FREE && skip) begin
                skip <= 1'b0;
              end else if (req.kind != pmvct_pkg::KIND_FIND_FREE || !res.found) begin
                res.found       <= 1'b1;
                res.found_block <= 6'(ev_idx);
                res.found_count <= blk_rd.count;
              end
            end
            if (ev_idx == BAW'(USER_BLOCKS - 1)) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
